// File: rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types, register indexes and status codes of the stuffed frame
// receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int BYTE_W            = 8;
    localparam int CFG_INDEX_W       = 3;
    localparam int ITEM_W            = 9;
    localparam int RAW_FRAME_MAX_DEF = 256;

    typedef logic [BYTE_W-1:0]      byte_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    typedef logic [ITEM_W-1:0]      item_cnt_t;

    localparam item_cnt_t ITEM_MAX = '1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_ADDR  = 3'd1,
        ST_TOO_LONG  = 3'd2,
        ST_BAD_SUM   = 3'd3,
        ST_OVERFLOW  = 3'd4
    } status_t;

    localparam cfg_index_t CFG_STATION_ADDRESS = 3'd0;
    localparam cfg_index_t CFG_MASTER_MODE     = 3'd1;
    localparam cfg_index_t CFG_ECHO_ENABLE     = 3'd2;
    localparam cfg_index_t CFG_START_CODE      = 3'd3;
    localparam cfg_index_t CFG_STOP_CODE       = 3'd4;
    localparam cfg_index_t CFG_ESCAPE_CODE     = 3'd5;
    localparam cfg_index_t CFG_MAX_PAYLOAD     = 3'd6;

    localparam byte_t RST_STATION_ADDRESS = 8'd0;
    localparam logic  RST_MASTER_MODE     = 1'b1;
    localparam logic  RST_ECHO_ENABLE     = 1'b1;
    localparam byte_t RST_START_CODE      = 8'd2;
    localparam byte_t RST_STOP_CODE       = 8'd3;
    localparam byte_t RST_ESCAPE_CODE     = 8'd16;
    localparam byte_t RST_MAX_PAYLOAD     = 8'd255;

    typedef struct packed {
        byte_t station_address;
        logic  master_mode;
        logic  echo_enable;
        byte_t start_code;
        byte_t stop_code;
        byte_t escape_code;
        byte_t max_payload;
    } cfg_t;

    typedef struct packed {
        logic    echo_valid;
        byte_t   echo_byte;
        logic    data_valid;
        byte_t   data_byte;
        logic    frame_done;
        status_t status;
        byte_t   payload_length;
    } result_t;

endpackage

// File: rtl/sfr_if.sv
// ----------------------------------------------------------------------------
// sfr_if
// Request channels of the stuffed frame receiver: received bytes in,
// decode results out.
// ----------------------------------------------------------------------------
interface sfr_rx_if;
    logic           valid;
    logic           ready;
    sfr_pkg::byte_t rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfr_res_if;
    logic             valid;
    logic             ready;
    logic             echo_valid;
    sfr_pkg::byte_t   echo_byte;
    logic             data_valid;
    sfr_pkg::byte_t   data_byte;
    logic             frame_done;
    sfr_pkg::status_t status;
    sfr_pkg::byte_t   payload_length;

    modport source (output valid, output echo_valid, output echo_byte, output data_valid,
                    output data_byte, output frame_done, output status,
                    output payload_length, input ready);
    modport sink   (input valid, input echo_valid, input echo_byte, input data_valid,
                    input data_byte, input frame_done, input status,
                    input payload_length, output ready);
endinterface

// File: rtl/stuffed_frame_receiver.sv
// ----------------------------------------------------------------------------
// stuffed_frame_receiver
// Byte-stuffed serial frame receiver with address check, XOR checksum,
// line echo and end-of-frame status.
// ----------------------------------------------------------------------------
// Takes one received byte per clock and returns exactly one result request per
// byte: the byte is registered in the input register, decoded against the
// frame state, and the result is held in an output register. The frame state
// updates once per byte, so the sustained rate is one byte per cycle while the
// result side keeps up; a stalled result holds the input register and, in the
// same cycle, the input side whenever that register is occupied. Configuration
// is written through cfg_we/cfg_index/cfg_data and must only change while no
// byte is in flight. Frames longer than RAW_FRAME_MAX raw bytes report the
// overflow status unless an earlier error was already recorded.
module stuffed_frame_receiver #(
    parameter int RAW_FRAME_MAX = sfr_pkg::RAW_FRAME_MAX_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    sfr_rx_if.sink              rx,
    sfr_res_if.source           res,
    input  logic                cfg_we,
    input  sfr_pkg::cfg_index_t cfg_index,
    input  sfr_pkg::byte_t      cfg_data
);
    import sfr_pkg::*;

    cfg_t    cfg;
    result_t result;
    result_t result_reg;
    logic    st_valid_reg;
    byte_t   st_byte_reg;
    logic    res_valid_reg;
    logic    res_valid_next;
    logic    advance;

    sfr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sfr_decode #(
        .RAW_FRAME_MAX (RAW_FRAME_MAX)
    ) u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .rx_byte (st_byte_reg),
        .cfg     (cfg),
        .result  (result)
    );

    assign advance  = st_valid_reg && (!res_valid_reg || res.ready);
    assign rx.ready = !st_valid_reg || advance;

    always_comb
    begin
        if (advance)
            res_valid_next = 1'b1;
        else if (res.ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (rx.ready)
                st_valid_reg <= rx.valid;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
            st_byte_reg <= rx.rx_byte;
        if (advance)
            result_reg <= result;
    end

    assign res.valid          = res_valid_reg;
    assign res.echo_valid     = result_reg.echo_valid;
    assign res.echo_byte      = result_reg.echo_byte;
    assign res.data_valid     = result_reg.data_valid;
    assign res.data_byte      = result_reg.data_byte;
    assign res.frame_done     = result_reg.frame_done;
    assign res.status         = result_reg.status;
    assign res.payload_length = result_reg.payload_length;

    // a stalled result holds the byte in the input register
    a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
        st_valid_reg && res_valid_reg && !res.ready |=> st_valid_reg)
        else $error("input register lost a byte while result stalled");

    // every registered byte yields a result
    a_byte_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        st_valid_reg && !res_valid_reg |=> res_valid_reg)
        else $error("registered byte produced no result");

    // status fields only accompany a frame end
    a_status_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.frame_done |-> res.status == ST_OK && res.payload_length == '0)
        else $error("status reported without frame end");

endmodule

// File: rtl/sfr_cfg.sv
// ----------------------------------------------------------------------------
// sfr_cfg
// Configuration register bank, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module sfr_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  sfr_pkg::cfg_index_t cfg_index,
    input  sfr_pkg::byte_t      cfg_data,
    output sfr_pkg::cfg_t       cfg
);
    import sfr_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_STATION_ADDRESS: cfg_next.station_address = cfg_data;
                CFG_MASTER_MODE:     cfg_next.master_mode     = cfg_data[0];
                CFG_ECHO_ENABLE:     cfg_next.echo_enable     = cfg_data[0];
                CFG_START_CODE:      cfg_next.start_code      = cfg_data;
                CFG_STOP_CODE:       cfg_next.stop_code       = cfg_data;
                CFG_ESCAPE_CODE:     cfg_next.escape_code     = cfg_data;
                CFG_MAX_PAYLOAD:     cfg_next.max_payload     = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.station_address <= RST_STATION_ADDRESS;
            cfg_reg.master_mode     <= RST_MASTER_MODE;
            cfg_reg.echo_enable     <= RST_ECHO_ENABLE;
            cfg_reg.start_code      <= RST_START_CODE;
            cfg_reg.stop_code       <= RST_STOP_CODE;
            cfg_reg.escape_code     <= RST_ESCAPE_CODE;
            cfg_reg.max_payload     <= RST_MAX_PAYLOAD;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/sfr_decode.sv
// ----------------------------------------------------------------------------
// sfr_decode
// Frame state and per-byte decode: unstuffing, address and XOR checksum
// checks, one-late payload delivery and end-of-frame status.
// ----------------------------------------------------------------------------
module sfr_decode #(
    parameter int RAW_FRAME_MAX = sfr_pkg::RAW_FRAME_MAX_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  sfr_pkg::byte_t   rx_byte,
    input  sfr_pkg::cfg_t    cfg,
    output sfr_pkg::result_t result
);
    import sfr_pkg::*;

    localparam int               RAW_W     = $clog2(RAW_FRAME_MAX + 1);
    localparam logic [RAW_W-1:0] RAW_LIMIT = RAW_W'(RAW_FRAME_MAX);

    logic             frame_open_reg,     frame_open_next;
    logic             echo_stop_seen_reg, echo_stop_seen_next;
    logic             escape_pending_reg, escape_pending_next;
    logic [RAW_W-1:0] raw_count_reg,      raw_count_next;
    item_cnt_t        decoded_count_reg,  decoded_count_next;
    byte_t            running_xor_reg,    running_xor_next;
    byte_t            held_byte_reg,      held_byte_next;
    logic             held_valid_reg,     held_valid_next;
    status_t          frame_error_reg,    frame_error_next;

    always_comb
    begin
        logic      take;
        logic      finish;
        logic      echo_master;
        byte_t     item;
        item_cnt_t count_m2;

        take        = 1'b0;
        finish      = 1'b0;
        item        = rx_byte;
        echo_master = cfg.master_mode && cfg.echo_enable;
        count_m2    = '0;

        result              = '0;
        frame_open_next     = frame_open_reg;
        echo_stop_seen_next = echo_stop_seen_reg;
        escape_pending_next = escape_pending_reg;
        raw_count_next      = raw_count_reg;
        decoded_count_next  = decoded_count_reg;
        running_xor_next    = running_xor_reg;
        held_byte_next      = held_byte_reg;
        held_valid_next     = held_valid_reg;
        frame_error_next    = frame_error_reg;

        if (!cfg.master_mode && cfg.echo_enable)
        begin
            result.echo_valid = 1'b1;
            result.echo_byte  = rx_byte;
        end

        // start code always reopens the frame
        if (rx_byte == cfg.start_code)
        begin
            frame_open_next     = 1'b1;
            echo_stop_seen_next = 1'b0;
            raw_count_next      = '0;
            escape_pending_next = 1'b0;
            decoded_count_next  = '0;
            running_xor_next    = '0;
            held_byte_next      = '0;
            held_valid_next     = 1'b0;
            frame_error_next    = ST_OK;
        end

        if (frame_open_next)
        begin
            if (raw_count_next < RAW_LIMIT)
                raw_count_next = raw_count_next + 1'b1;
            else if (frame_error_next == ST_OK)
                frame_error_next = ST_OVERFLOW;

            if (rx_byte == cfg.stop_code)
            begin
                if (echo_master && !echo_stop_seen_next)
                begin
                    // end of own echo: restart decoding
                    echo_stop_seen_next = 1'b1;
                    raw_count_next      = '0;
                    escape_pending_next = 1'b0;
                    decoded_count_next  = '0;
                    running_xor_next    = '0;
                    held_byte_next      = '0;
                    held_valid_next     = 1'b0;
                    frame_error_next    = ST_OK;
                end
                else
                begin
                    if (escape_pending_next)
                    begin
                        escape_pending_next = 1'b0;
                        take                = 1'b1;
                        item                = rx_byte + cfg.start_code;
                    end
                    finish = 1'b1;
                end
            end
            else if (!(rx_byte == cfg.start_code && !cfg.master_mode))
            begin
                if (escape_pending_next)
                begin
                    escape_pending_next = 1'b0;
                    take                = 1'b1;
                    item                = rx_byte + cfg.start_code;
                end
                else if (rx_byte == cfg.escape_code)
                begin
                    escape_pending_next = 1'b1;
                end
                else
                begin
                    take = 1'b1;
                end
            end
        end

        if (take)
        begin
            if (decoded_count_next == '0)
            begin
                if (item != cfg.station_address && frame_error_next == ST_OK)
                    frame_error_next = ST_BAD_ADDR;
                running_xor_next = item;
            end
            else
            begin
                running_xor_next = running_xor_next ^ item;
                if ((decoded_count_next - 1'b1) > ITEM_W'(cfg.max_payload)
                    && frame_error_next == ST_OK)
                    frame_error_next = ST_TOO_LONG;
                if (held_valid_next && frame_error_next == ST_OK)
                begin
                    result.data_valid = 1'b1;
                    result.data_byte  = held_byte_next;
                end
                held_byte_next  = item;
                held_valid_next = 1'b1;
            end
            if (decoded_count_next != ITEM_MAX)
                decoded_count_next = decoded_count_next + 1'b1;
        end

        if (finish)
        begin
            result.frame_done = 1'b1;
            if (frame_error_next != ST_OK)
                result.status = frame_error_next;
            else if (decoded_count_next == ITEM_W'(0))
                result.status = ST_BAD_ADDR;
            else if (decoded_count_next == ITEM_W'(1))
                result.status = ST_BAD_SUM;
            else if (running_xor_next == '0)
                result.status = ST_OK;
            else
                result.status = ST_BAD_SUM;

            count_m2 = decoded_count_next - ITEM_W'(2);
            if (decoded_count_next >= ITEM_W'(2))
            begin
                if (count_m2 > ITEM_W'(255))
                    result.payload_length = '1;
                else
                    result.payload_length = count_m2[BYTE_W-1:0];
            end

            frame_open_next     = 1'b0;
            echo_stop_seen_next = 1'b0;
            held_valid_next     = 1'b0;
            escape_pending_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg     <= 1'b0;
            echo_stop_seen_reg <= 1'b0;
            escape_pending_reg <= 1'b0;
            raw_count_reg      <= '0;
            decoded_count_reg  <= '0;
            running_xor_reg    <= '0;
            held_byte_reg      <= '0;
            held_valid_reg     <= 1'b0;
            frame_error_reg    <= ST_OK;
        end
        else if (advance)
        begin
            frame_open_reg     <= frame_open_next;
            echo_stop_seen_reg <= echo_stop_seen_next;
            escape_pending_reg <= escape_pending_next;
            raw_count_reg      <= raw_count_next;
            decoded_count_reg  <= decoded_count_next;
            running_xor_reg    <= running_xor_next;
            held_byte_reg      <= held_byte_next;
            held_valid_reg     <= held_valid_next;
            frame_error_reg    <= frame_error_next;
        end
    end

endmodule
